@@ rtl/ffra_pkg.sv @@
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared sizes, types and codes of the first-fit rectangle allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int DIM_W   = 9;
  localparam int POS_W   = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SHAMT_W = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W   = (DIM_W > COL_W + 1) ? DIM_W : COL_W + 1;

  localparam int CHUNK  = 8;
  localparam int OFS_W  = $clog2(CHUNK);
  localparam int NCHUNK = (MAX_WIDTH + CHUNK - 1) / CHUNK;
  localparam int GRP_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD_W  = NCHUNK * CHUNK;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IDX  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IDX = 1'b1;
  localparam logic [DIM_W-1:0]     CFG_DIM_RESET  = 9'd256;

  typedef logic [MAX_WIDTH-1:0] row_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_FREE,
    S_WIDEN,
    S_GROUP,
    S_PICK,
    S_MASK_LEN,
    S_MASK_POS,
    S_MREAD,
    S_MWRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic update;
  } runs_ctrl_t;

endpackage

@@ rtl/ffra_ram.sv @@
// ----------------------------------------------------------------------------
// ffra_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ffra_shifter.sv @@
// ----------------------------------------------------------------------------
// ffra_shifter
// Shared row-wide barrel shifter, left or right by a variable amount.
// ----------------------------------------------------------------------------
module ffra_shifter (
  input  ffra_pkg::row_t                   data,
  input  logic [ffra_pkg::SHAMT_W-1:0]     amount,
  input  logic                             left,
  output ffra_pkg::row_t                   result
);

  import ffra_pkg::*;

  assign result = left ? (data << amount) : (data >> amount);

endmodule

@@ rtl/ffra_runs.sv @@
// ----------------------------------------------------------------------------
// ffra_runs
// Per-column free-run counters over the rows scanned so far, and the mask
// of columns whose run covers the request height inside the area in use.
// ----------------------------------------------------------------------------
module ffra_runs (
  input  logic                         clk,
  input  ffra_pkg::runs_ctrl_t         ctrl,
  input  ffra_pkg::row_t               occupied,
  input  logic [ffra_pkg::DIM_W-1:0]   rect_h,
  input  logic [ffra_pkg::DIM_W-1:0]   area_w,
  output ffra_pkg::row_t               free
);

  import ffra_pkg::*;

  logic [DIM_W-1:0] run [MAX_WIDTH];

  always_ff @(posedge clk) begin
    for (int x = 0; x < MAX_WIDTH; x++) begin
      if (ctrl.clear) begin
        run[x] <= '0;
      end else if (ctrl.update) begin
        if (occupied[x]) begin
          run[x] <= '0;
        end else if (run[x] != '1) begin
          run[x] <= run[x] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int x = 0; x < MAX_WIDTH; x++) begin
      free[x] = (run[x] >= rect_h) && (CMP_W'(x) < CMP_W'(area_w));
    end
  end

endmodule

@@ rtl/first_fit_rectangle_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// first_fit_rectangle_allocator_unit
// A rejected or zero-size request goes straight to the finish state. Otherwise
// rows are scanned top-down; each is read and its free-run counters updated.
// From the request height on, a row's free mask is widened to the request
// width on the shared shifter, grouped and searched; a hit is marked into each
// covered row, then the result is given. One transaction at a time.
// Reset: bitmap reads as free through per-row valid bits, all cleared at reset.
// ----------------------------------------------------------------------------
module first_fit_rectangle_allocator_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ffra_pkg::DIM_W-1:0]       rect_width,
  input  logic [ffra_pkg::DIM_W-1:0]       rect_height,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             placed,
  output logic [ffra_pkg::POS_W-1:0]       pos_x,
  output logic [ffra_pkg::POS_W-1:0]       pos_y,
  input  logic                             cfg_we,
  input  logic [ffra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ffra_pkg::DIM_W-1:0]       cfg_data
);

  import ffra_pkg::*;

  state_t state, state_next;

  logic [DIM_W-1:0]   width_in_use, height_in_use;
  logic [DIM_W-1:0]   area_w, area_h;
  logic [DIM_W-1:0]   rw, rh;
  logic [ROW_W-1:0]   row_ptr, mark_last, top_row;
  logic [COL_W-1:0]   fx, pick_x;
  logic [DIM_W-1:0]   span, step;
  logic [NCHUNK-1:0]  chunk_any;
  logic [MAX_HEIGHT-1:0] row_valid;
  logic               rd_valid;
  row_t               win, rd_data, row_eff, free, sh_data, sh_out;
  logic [PAD_W-1:0]   win_pad;
  logic [CHUNK-1:0]   chunk_bits;
  logic [GRP_W-1:0]   pick_grp;
  logic [OFS_W-1:0]   pick_ofs;
  logic [SHAMT_W-1:0] sh_amt;
  logic               sh_left;
  logic               res_placed;
  logic [POS_W-1:0]   res_x, res_y;
  logic               in_take, req_fits, req_zero, eligible, last_row;
  logic               widen_done, pick_hit, mark_done, out_free, ram_we;
  runs_ctrl_t         runs_ctrl;

  // area in use, clamped to the bitmap
  assign area_w = (int'(width_in_use) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_in_use;
  assign area_h = (int'(height_in_use) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_in_use;

  assign in_take    = in_valid && !in_stall;
  assign req_fits   = (area_w != '0) && (area_h != '0) &&
                      (rect_width <= area_w) && (rect_height <= area_h);
  assign req_zero   = (rect_width == '0) || (rect_height == '0);
  assign eligible   = (int'(row_ptr) + 1) >= int'(rh);
  assign last_row   = int'(row_ptr) == (int'(area_h) - 1);
  assign widen_done = span == rw;
  assign step       = (span <= (rw - span)) ? span : (rw - span);
  assign mark_done  = row_ptr == mark_last;
  assign out_free   = !out_valid || !out_stall;
  assign top_row    = ROW_W'(int'(row_ptr) + 1 - int'(rh));
  assign row_eff    = rd_valid ? rd_data : '0;
  assign win_pad    = PAD_W'(win);
  assign pick_hit   = |chunk_any;

  always_comb begin
    pick_grp = '0;
    for (int g = NCHUNK - 1; g >= 0; g--) begin
      if (chunk_any[g]) begin
        pick_grp = GRP_W'(g);
      end
    end
    chunk_bits = win_pad[int'(pick_grp) * CHUNK +: CHUNK];
    pick_ofs = '0;
    for (int b = CHUNK - 1; b >= 0; b--) begin
      if (chunk_bits[b]) begin
        pick_ofs = OFS_W'(b);
      end
    end
    pick_x = COL_W'(int'(pick_grp) * CHUNK + int'(pick_ofs));
  end

  ffra_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_ptr),
    .wdata (row_eff | win),
    .raddr (row_ptr),
    .rdata (rd_data)
  );

  ffra_runs u_runs (
    .clk      (clk),
    .ctrl     (runs_ctrl),
    .occupied (row_eff),
    .rect_h   (rh),
    .area_w   (area_w),
    .free     (free)
  );

  ffra_shifter u_shift (
    .data   (sh_data),
    .amount (sh_amt),
    .left   (sh_left),
    .result (sh_out)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = (!req_fits || req_zero) ? S_DONE : S_READ;
        end
      end
      S_READ:     state_next = S_UPDATE;
      S_UPDATE: begin
        if (eligible) begin
          state_next = S_FREE;
        end else begin
          state_next = last_row ? S_DONE : S_READ;
        end
      end
      S_FREE:     state_next = S_WIDEN;
      S_WIDEN: begin
        if (widen_done) begin
          state_next = S_GROUP;
        end
      end
      S_GROUP:    state_next = S_PICK;
      S_PICK: begin
        if (pick_hit) begin
          state_next = S_MASK_LEN;
        end else begin
          state_next = last_row ? S_DONE : S_READ;
        end
      end
      S_MASK_LEN: state_next = S_MASK_POS;
      S_MASK_POS: state_next = S_MREAD;
      S_MREAD:    state_next = S_MWRITE;
      S_MWRITE:   state_next = mark_done ? S_DONE : S_MREAD;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // control decode
  always_comb begin
    in_stall         = state != S_IDLE;
    runs_ctrl.clear  = state == S_IDLE;
    runs_ctrl.update = state == S_UPDATE;
    ram_we           = state == S_MWRITE;
    sh_data          = win;
    sh_amt           = '0;
    sh_left          = 1'b0;
    case (state)
      S_WIDEN: begin
        sh_amt = SHAMT_W'(step);
      end
      S_MASK_LEN: begin
        sh_data = '1;
        sh_amt  = SHAMT_W'(MAX_WIDTH - int'(rw));
      end
      S_MASK_POS: begin
        sh_amt  = SHAMT_W'(fx);
        sh_left = 1'b1;
      end
      default: begin
        sh_amt = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      width_in_use  <= CFG_DIM_RESET;
      height_in_use <= CFG_DIM_RESET;
      row_valid     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH_IDX:  width_in_use  <= cfg_data;
          CFG_HEIGHT_IDX: height_in_use <= cfg_data;
          default: ;
        endcase
      end
      if (ram_we) begin
        row_valid[row_ptr] <= 1'b1;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_valid <= row_valid[row_ptr];
    case (state)
      S_IDLE: begin
        if (in_take) begin
          rw         <= rect_width;
          rh         <= rect_height;
          row_ptr    <= '0;
          res_placed <= req_fits;
          res_x      <= '0;
          res_y      <= '0;
        end
      end
      S_UPDATE: begin
        if (!eligible) begin
          if (last_row) begin
            res_placed <= 1'b0;
          end else begin
            row_ptr <= row_ptr + 1'b1;
          end
        end
      end
      S_FREE: begin
        win  <= free;
        span <= DIM_W'(1);
      end
      S_WIDEN: begin
        if (!widen_done) begin
          win  <= win & sh_out;
          span <= span + step;
        end
      end
      S_GROUP: begin
        for (int g = 0; g < NCHUNK; g++) begin
          chunk_any[g] <= |win_pad[g * CHUNK +: CHUNK];
        end
      end
      S_PICK: begin
        if (pick_hit) begin
          fx         <= pick_x;
          mark_last  <= row_ptr;
          row_ptr    <= top_row;
          res_placed <= 1'b1;
          res_x      <= POS_W'(pick_x);
          res_y      <= POS_W'(top_row);
        end else if (last_row) begin
          res_placed <= 1'b0;
        end else begin
          row_ptr <= row_ptr + 1'b1;
        end
      end
      S_MASK_LEN, S_MASK_POS: begin
        win <= sh_out;
      end
      S_MWRITE: begin
        if (!mark_done) begin
          row_ptr <= row_ptr + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          placed <= res_placed;
          pos_x  <= res_x;
          pos_y  <= res_y;
        end
      end
      default: ;
    endcase
  end

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the finish state");

  a_fail_zero_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !placed) |-> (pos_x == '0 && pos_y == '0))
    else $error("failed transaction carries nonzero position");

  a_mark_in_area: assert property (@(posedge clk) disable iff (rst)
    (state == S_MWRITE) |-> (int'(row_ptr) < int'(area_h)))
    else $error("marking a row outside the area in use");

  a_pick_in_area: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK && pick_hit) |-> (int'(pick_x) + int'(rw) <= int'(area_w)))
    else $error("picked column range exceeds the area in use");

endmodule
